### hdl/sil_pkg.sv
// Package with types, constants and command codes for the sorted interval lookup.
package sil_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  chromosome;
    logic [30:0] region_start;
    logic [30:0] region_end;
    logic [30:0] query_pos;
  } in_item_t;

  typedef struct packed {
    logic [15:0] label;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  chrom;
    logic [30:0] start;
    logic [30:0] stop;
    logic [15:0] label;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } fsm_t;

  // Memory access request from the controller.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

### hdl/sil_ram.sv
// Single table memory: one write and one registered read per cycle.
module sil_ram
  import sil_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### hdl/sil_ctrl.sv
// Controller: binary search, insert shift sequencer and result register.
module sil_ctrl
  import sil_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  output mem_req_t  req,
  input  entry_t    rd_data
);

  fsm_t             state, state_next;
  in_item_t         item;
  logic [CNT_W-1:0] count, lo, hi, mid;
  logic [15:0]      counter;
  logic [CNT_W-1:0] shift_idx;
  logic             skip_write;
  logic             place_new;
  logic [30:0]      key_s;
  logic             not_above;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign mid = lo + ((hi - lo) >> 1);
  assign key_s = (item.command == CMD_LOOKUP) ? item.query_pos : item.region_start;
  assign not_above = (rd_data.chrom < item.chromosome) ||
                     ((rd_data.chrom == item.chromosome) && (rd_data.start <= key_s));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
      place_new <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            lo   <= '0;
            hi   <= count;
            if (in_data.command == CMD_INSERT && counter != 16'hFFFF) begin
              counter <= counter + 16'd1;
            end
            if (in_data.command == CMD_CLEAR || in_data.command == CMD_NOP) begin
              if (in_data.command == CMD_CLEAR) begin
                count   <= '0;
                counter <= '0;
              end
              out_data  <= '{label: 16'd0, status: ST_OK};
              out_valid <= 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (not_above) lo <= mid + 1'b1;
          else hi <= mid;
        end
        S_DECIDE: begin
          // lo is the predecessor count; entry lo-1 was read when lo > 0.
          if (item.command == CMD_LOOKUP) begin
            out_valid       <= 1'b1;
            out_data.status <= ST_OK;
            out_data.label  <= (lo != '0 && rd_data.chrom == item.chromosome &&
                                rd_data.stop >= item.query_pos) ? rd_data.label : 16'd0;
          end else if (lo != '0 && rd_data.chrom == item.chromosome &&
                       rd_data.start == item.region_start) begin
            out_valid <= 1'b1;
            out_data  <= '{label: 16'd0, status: ST_DUP};
          end else if (count == CNT_W'(TABLE_DEPTH)) begin
            out_valid <= 1'b1;
            out_data  <= '{label: 16'd0, status: ST_FULL};
          end else begin
            out_data   <= '{label: counter, status: ST_OK};
            shift_idx  <= count;
            skip_write <= 1'b1;
          end
        end
        S_SHIFT: begin
          skip_write <= 1'b0;
          shift_idx  <= shift_idx - 1'b1;
          if (shift_idx == lo) begin
            count     <= count + 1'b1;
            place_new <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        S_DONE: place_new <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    req = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready &&
            (in_data.command == CMD_INSERT || in_data.command == CMD_LOOKUP)) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo < hi) begin
          req.rd_en   = 1'b1;
          req.rd_addr = mid[IDX_W-1:0];
          state_next  = S_WAIT;
        end else begin
          req.rd_en   = (lo != '0);
          req.rd_addr = IDX_W'(lo - 1'b1);
          state_next  = S_DECIDE;
        end
      end
      S_WAIT: state_next = S_SEARCH;
      S_DECIDE: begin
        state_next = S_DONE;
        if (item.command == CMD_INSERT &&
            !(lo != '0 && rd_data.chrom == item.chromosome &&
              rd_data.start == item.region_start) &&
            count != CNT_W'(TABLE_DEPTH)) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Each cycle writes the entry read last cycle one place up and reads the next.
        if (!skip_write) begin
          req.wr_en   = 1'b1;
          req.wr_addr = IDX_W'(shift_idx + 1'b1);
          req.wr_data = rd_data;
        end
        if (shift_idx == lo) begin
          state_next = S_DONE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = IDX_W'(shift_idx - 1'b1);
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
        // The new region goes into the slot freed at the insertion point.
        if (place_new) begin
          req.wr_en   = 1'b1;
          req.wr_addr = lo[IDX_W-1:0];
          req.wr_data = '{chrom: item.chromosome, start: item.region_start,
                          stop: item.region_end, label: counter};
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_shift_stays_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (shift_idx >= lo && count < CNT_W'(TABLE_DEPTH)))
    else $error("shift index out of range");
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo <= hi && hi <= count))
    else $error("search window broken");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("ready while busy");

endmodule

### hdl/sorted_interval_label_lookup.sv
// Top level of the sorted interval label lookup block.
// Regions are kept sorted by (chromosome, start) in one synchronous memory of
// TABLE_DEPTH entries. A lookup is a binary search: each probe reads the middle
// entry of the window and narrows the window, and then the entry just below the
// found place is read to form the result. An insert runs the same search and,
// for a new start with room left, moves every entry above the insertion point
// up by one place, one entry per cycle through the single memory port pair;
// the new region is written in the closing cycle. Clear and unused commands
// are answered from the idle state without a memory access. One transaction
// is processed at a time; the result sits in an output register and the next
// input transaction is taken once it has been delivered. No clearing pass is
// needed after reset, since only entries below the fill count are ever read.
module sorted_interval_label_lookup
  import sil_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mem_req_t req;
  entry_t   rd_data;

  sil_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .req, .rd_data
  );

  sil_ram u_ram (.clk, .req, .rd_data);

endmodule
